// File: sv/mtsg_pkg.sv
// mtsg_pkg: shared widths, register map codes, config struct and sine table builder
// for the multi-tone sine generator; no dependencies
`default_nettype none

package mtsg_pkg;

    // default values of the top level parameters
    localparam int DEF_MAX_TONES       = 4;
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_TABLE_ADDR_BITS = 8;
    localparam int DEF_SAMPLE_BITS     = 16;

    // fixed field widths
    localparam int TC_W   = 3;
    localparam int STEP_W = 32;
    localparam int AMP_W  = 15;
    localparam int DUR_W  = 24;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    // register indexes (byte address is four times the index)
    localparam logic [IDX_W-1:0] REG_TONE_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEP_A     = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP_D     = 3'd4;
    localparam logic [IDX_W-1:0] REG_AMPLITUDE  = 3'd5;
    localparam logic [IDX_W-1:0] REG_DURATION   = 3'd6;

    // sine table scaling, Q30 fixed point
    localparam logic [63:0] Q_ONE       = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TBL_MAX     = 64'd32767;

    typedef struct packed {
        logic [TC_W-1:0]  tone_count;
        logic [AMP_W-1:0] amplitude;
        logic [DUR_W-1:0] duration;
    } t_cfg;

    // quarter-wave entry k of a table with 2^abits steps, Taylor series to x^11
    function automatic logic [AMP_W-1:0] quarter_entry(input int unsigned k,
                                                       input int unsigned abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        x  = (64'(k) * HALF_PI_Q30) >> abits;
        x2 = (x * x) >> 30;
        t  = Q_ONE - x2 / 64'd110;
        t  = Q_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (e > TBL_MAX) begin
            e = TBL_MAX;
        end
        return e[AMP_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/mtsg_if.sv
// mtsg_in_if / mtsg_out_if: valid/ready item channels of the sine generator
// depends on mtsg_pkg for the default sample width
`default_nettype none

interface mtsg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface mtsg_out_if #(
    parameter int SAMPLE_BITS = mtsg_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          active;
    logic                          last;

    modport source (output valid, output sample, output active, output last, input ready);
    modport sink   (input valid, input sample, input active, input last, output ready);
endinterface

`default_nettype wire

// File: sv/multi_tone_sine_generator_top.sv
// Multi-tone sine generator: each accepted input item produces one sample, the
// wrapping sum of up to MAX_TONES table-driven sine tones while a beep plays and zero
// otherwise. An item with restart set zeroes all phases and loads the configured
// duration; the last sample of a beep carries last. The block takes one item per clock
// while its output register is empty or being taken, and its result sits in the output
// register in the cycle after acceptance. The clock period is set by the single
// registered pass from the phase registers through the sine table, the amplitude
// multiplier and the adder chain over the tones. The user must write registers over
// the apb port only while no item is in flight; the block itself does not enforce it.
// depends on mtsg_pkg, mtsg_if, mtsg_cfg and mtsg_tone
`default_nettype none

module multi_tone_sine_generator_top #(
    parameter int MAX_TONES       = mtsg_pkg::DEF_MAX_TONES,
    parameter int PHASE_BITS      = mtsg_pkg::DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = mtsg_pkg::DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = mtsg_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mtsg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mtsg_pkg::DATA_W-1:0] pwdata,
    output logic      [mtsg_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    mtsg_in_if.sink                          i_in_ch,
    mtsg_out_if.source                       o_out_ch
);
    import mtsg_pkg::*;

    localparam int STEP_EXT_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    t_cfg                   cfg;
    logic [STEP_W-1:0]      tone_step [MAX_TONES];

    logic [PHASE_BITS-1:0]  r_phase [MAX_TONES];
    logic [PHASE_BITS-1:0]  n_phase [MAX_TONES];
    logic [DUR_W-1:0]       r_left;
    logic                   r_playing;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_active;
    logic                   r_last;

    logic                   accept;
    logic                   restart;
    logic                   play_eff;
    logic [DUR_W-1:0]       left_eff;
    logic [DUR_W-1:0]       left_dec;
    logic                   final_smp;
    logic [PHASE_BITS-1:0]  phase_eff [MAX_TONES];
    logic [SAMPLE_BITS-1:0] term [MAX_TONES];
    logic [MAX_TONES-1:0]   tone_en;
    logic [SAMPLE_BITS-1:0] sum;

    // register file
    mtsg_cfg #(
        .MAX_TONES (MAX_TONES)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata),
        .o_cfg       (cfg),
        .o_tone_step (tone_step)
    );

    assign pready = 1'b1;

    // handshake, output register drains while a new item comes in
    assign i_in_ch.ready = !r_out_valid || o_out_ch.ready;
    assign accept        = i_in_ch.valid && i_in_ch.ready;
    assign restart       = i_in_ch.restart;

    // beep state as seen by this item after a possible restart
    assign play_eff  = restart ? (cfg.duration != '0) : r_playing;
    assign left_eff  = restart ? cfg.duration : r_left;
    assign left_dec  = left_eff - DUR_W'(1);
    assign final_smp = (left_dec == '0);

    // per-tone phase, term and next phase
    for (genvar g = 0; g < MAX_TONES; g++) begin : g_tone
        logic [STEP_EXT_W-1:0] step_ext;

        assign step_ext     = STEP_EXT_W'(tone_step[g]);
        assign phase_eff[g] = restart ? '0 : r_phase[g];
        assign tone_en[g]   = TC_W'(g) < cfg.tone_count;
        assign n_phase[g]   = (play_eff && tone_en[g])
                              ? phase_eff[g] + step_ext[PHASE_BITS-1:0]
                              : phase_eff[g];

        mtsg_tone #(
            .PHASE_BITS      (PHASE_BITS),
            .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
            .SAMPLE_BITS     (SAMPLE_BITS)
        ) u_tone (
            .i_phase     (phase_eff[g]),
            .i_amplitude (cfg.amplitude),
            .o_term      (term[g])
        );
    end

    // wrapping sum over the enabled tones
    always_comb begin
        sum = '0;
        for (int t = 0; t < MAX_TONES; t++) begin
            if (tone_en[t]) begin
                sum = sum + term[t];
            end
        end
    end

    // beep state and phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_playing <= 1'b0;
            for (int t = 0; t < MAX_TONES; t++) begin
                r_phase[t] <= '0;
            end
        end else if (accept) begin
            r_phase <= n_phase;
            if (play_eff) begin
                r_left    <= left_dec;
                r_playing <= !final_smp;
            end else begin
                r_left    <= left_eff;
                r_playing <= 1'b0;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, zero when idle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= play_eff ? sum : '0;
            r_active <= play_eff;
            r_last   <= play_eff && final_smp;
        end
    end

    assign o_out_ch.valid  = r_out_valid;
    assign o_out_ch.sample = r_sample;
    assign o_out_ch.active = r_active;
    assign o_out_ch.last   = r_last;

    // an idle item without restart gives a silent sample
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !restart && !r_playing) |=> (r_sample == '0 && !r_active && !r_last))
        else $error("idle item produced a non-silent sample");

    // a running beep always has samples left
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_left != '0))
        else $error("beep playing with no samples left");

    // the final sample of a beep ends it
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && play_eff && final_smp) |=> (!r_playing && r_last && r_active))
        else $error("beep continued past its final sample");

    // a restart with a nonzero duration starts an active beep
    a_restart_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && restart && cfg.duration != '0) |=> (r_out_valid && r_active))
        else $error("restart did not start a beep");

endmodule

`default_nettype wire

// File: sv/mtsg_cfg.sv
// mtsg_cfg: apb register file holding tone count, steps, amplitude and duration
// depends on mtsg_pkg
`default_nettype none

module mtsg_cfg #(
    parameter int MAX_TONES = mtsg_pkg::DEF_MAX_TONES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [mtsg_pkg::ADDR_W-1:0]   i_paddr,
    input  wire logic [mtsg_pkg::DATA_W-1:0]   i_pwdata,
    output logic      [mtsg_pkg::DATA_W-1:0]   o_prdata,
    output mtsg_pkg::t_cfg                     o_cfg,
    output logic      [mtsg_pkg::STEP_W-1:0]   o_tone_step [MAX_TONES]
);
    import mtsg_pkg::*;

    t_cfg             r_cfg;
    logic [STEP_W-1:0] r_step [MAX_TONES];
    logic [IDX_W-1:0]  reg_idx;
    logic [IDX_W-1:0]  step_sel;
    logic              wr_en;
    logic              step_hit;
    logic [STEP_W-1:0] step_rd;

    assign reg_idx  = i_paddr[ADDR_W-1:2];
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign step_sel = reg_idx - REG_STEP_A;
    assign step_hit = (reg_idx >= REG_STEP_A) && (reg_idx <= REG_STEP_D);

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            for (int t = 0; t < MAX_TONES; t++) begin
                r_step[t] <= '0;
            end
        end else if (wr_en) begin
            if (reg_idx == REG_TONE_COUNT) begin
                r_cfg.tone_count <= i_pwdata[TC_W-1:0];
            end
            if (reg_idx == REG_AMPLITUDE) begin
                r_cfg.amplitude <= i_pwdata[AMP_W-1:0];
            end
            if (reg_idx == REG_DURATION) begin
                r_cfg.duration <= i_pwdata[DUR_W-1:0];
            end
            for (int t = 0; t < MAX_TONES; t++) begin
                if (step_hit && (step_sel == IDX_W'(t))) begin
                    r_step[t] <= i_pwdata[STEP_W-1:0];
                end
            end
        end
    end

    // step readback, step registers without a tone read zero
    always_comb begin
        step_rd = '0;
        for (int t = 0; t < MAX_TONES; t++) begin
            if (step_hit && (step_sel == IDX_W'(t))) begin
                step_rd = r_step[t];
            end
        end
    end

    // read mux
    always_comb begin
        o_prdata = '0;
        if (step_hit) begin
            o_prdata = DATA_W'(step_rd);
        end else if (reg_idx == REG_TONE_COUNT) begin
            o_prdata = DATA_W'(r_cfg.tone_count);
        end else if (reg_idx == REG_AMPLITUDE) begin
            o_prdata = DATA_W'(r_cfg.amplitude);
        end else if (reg_idx == REG_DURATION) begin
            o_prdata = DATA_W'(r_cfg.duration);
        end
    end

    assign o_cfg       = r_cfg;
    assign o_tone_step = r_step;

endmodule

`default_nettype wire

// File: sv/mtsg_tone.sv
// mtsg_tone: one tone term, quarter-wave sine lookup times amplitude with sign
// depends on mtsg_pkg for the table builder and widths
`default_nettype none

module mtsg_tone #(
    parameter int PHASE_BITS      = mtsg_pkg::DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = mtsg_pkg::DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = mtsg_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic [PHASE_BITS-1:0]      i_phase,
    input  wire logic [mtsg_pkg::AMP_W-1:0] i_amplitude,
    output logic      [SAMPLE_BITS-1:0]     o_term
);
    import mtsg_pkg::*;

    localparam int QLEN   = 1 << TABLE_ADDR_BITS;
    localparam int ROM_AW = TABLE_ADDR_BITS + 1;
    localparam int TERM_W = AMP_W + 1;
    localparam int EXT_W  = (SAMPLE_BITS > TERM_W) ? SAMPLE_BITS : TERM_W;

    logic [AMP_W-1:0]           rom [0:QLEN];
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [ROM_AW-1:0]          addr;
    logic [AMP_W-1:0]           mag;
    logic [2*AMP_W-1:0]         prod_full;
    logic [AMP_W-1:0]           prod;
    logic signed [TERM_W-1:0]   term;
    logic [EXT_W-1:0]           term_ext;

    // constant quarter-wave table, entries 0 through QLEN inclusive
    for (genvar k = 0; k <= QLEN; k++) begin : g_rom
        assign rom[k] = quarter_entry(k, TABLE_ADDR_BITS);
    end

    // odd quadrants read the table backwards
    assign quad = i_phase[PHASE_BITS-1 -: 2];
    assign idx  = i_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign addr = quad[0] ? (ROM_AW'(QLEN) - {1'b0, idx}) : {1'b0, idx};
    assign mag  = rom[addr];

    // q0.15 scaling, truncation toward zero since the product is unsigned
    assign prod_full = (2*AMP_W)'(i_amplitude) * (2*AMP_W)'(mag);
    assign prod      = prod_full[2*AMP_W-1:AMP_W];

    // negative half of the wave
    assign term     = quad[1] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    assign term_ext = EXT_W'(term);
    assign o_term   = term_ext[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire
